@@ design/lket_pkg.sv @@
// types, codes and keymap layer tables for the layered keymap event translator
// used by lket_store, lket_decode and layered_keymap_event_translator
package lket_pkg;

    localparam int IDX_W  = 6;
    localparam int CODE_W = 9;
    localparam int KIND_W = 3;
    localparam int MODS_W = 3;
    localparam int TAB_N  = 64;

    // fifo event types
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_HOLD    = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KEY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CTRL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOD     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INVALID = 3'd5;

    // special key indices
    localparam logic [IDX_W-1:0] KEY_SHIFT_L = 6'd25;
    localparam logic [IDX_W-1:0] KEY_SHIFT_R = 6'd41;
    localparam logic [IDX_W-1:0] KEY_ALT     = 6'd30;
    localparam logic [IDX_W-1:0] KEY_FN      = 6'd37;
    localparam logic [IDX_W-1:0] KEY_CTRL    = 6'd33;

    localparam logic [CODE_W-1:0] CODE_LEFTCTRL = 9'd29;

    // modifier status bits
    localparam int MOD_SHIFT = 0;
    localparam int MOD_FN    = 2;

    typedef struct packed {
        logic [7:0]        fifo_byte;
        logic [MODS_W-1:0] modifier_status;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [CODE_W-1:0] key_code;
        logic              key_pressed;
        logic [IDX_W-1:0]  scan_index;
    } t_out_item;

    // record update toward the pressed-code store
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
    } t_store_wr;

    typedef logic [CODE_W-1:0] t_code_tab [TAB_N];

    localparam t_code_tab LAYER_NORMAL = '{
        9'd5,   9'd6,   9'd8,   9'd7,   9'd9,   9'd10,  9'd11,
        9'd19,  9'd20,  9'd22,  9'd21,  9'd23,  9'd24,  9'd25,
        9'd33,  9'd34,  9'd51,  9'd35,  9'd52,  9'd38,  9'd28,
        9'd4,   9'd18,  9'd46,  9'd32,  9'd42,  9'd50,  9'd57,
        9'd3,   9'd1,   9'd56,  9'd15,  9'd47,  9'd29,  9'd14,
        9'd2,   9'd16,  9'd464, 9'd44,  9'd48,  9'd49,  9'd54,
        9'd17,  9'd30,  9'd31,  9'd45,  9'd36,  9'd37,  9'd272, 9'd108,
        9'd103, 9'd106, 9'd105,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
    };

    localparam t_code_tab LAYER_SHIFT = '{
        9'd5,   9'd6,   9'd8,   9'd7,   9'd9,   9'd10,  9'd11,
        9'd19,  9'd20,  9'd22,  9'd21,  9'd23,  9'd24,  9'd25,
        9'd33,  9'd34,  9'd51,  9'd35,  9'd52,  9'd38,  9'd28,
        9'd4,   9'd18,  9'd46,  9'd32,  9'd42,  9'd50,  9'd57,
        9'd3,   9'd1,   9'd56,  9'd15,  9'd47,  9'd29,  9'd14,
        9'd2,   9'd16,  9'd464, 9'd44,  9'd48,  9'd49,  9'd54,
        9'd17,  9'd30,  9'd31,  9'd45,  9'd36,  9'd37,  9'd273, 9'd108,
        9'd103, 9'd106, 9'd105,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
    };

    localparam t_code_tab LAYER_FN = '{
        9'd62,  9'd63,  9'd65,  9'd64,  9'd66,  9'd67,  9'd68,
        9'd12,  9'd12,  9'd13,  9'd13,  9'd43,  9'd87,  9'd88,
        9'd40,  9'd26,  9'd53,  9'd27,  9'd107, 9'd102, 9'd28,
        9'd61,  9'd41,  9'd39,  9'd39,  9'd42,  9'd53,  9'd57,
        9'd60,  9'd1,   9'd56,  9'd15,  9'd40,  9'd29,  9'd14,
        9'd59,  9'd41,  9'd464, 9'd86,  9'd26,  9'd27,  9'd54,
        9'd103, 9'd105, 9'd106, 9'd108, 9'd30,  9'd48,  9'd274, 9'd108,
        9'd103, 9'd106, 9'd105,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
    };

    // fn layer wins over shift
    function automatic logic [CODE_W-1:0] layer_code(
        input logic [IDX_W-1:0]  idx,
        input logic [MODS_W-1:0] mods
    );
        logic [CODE_W-1:0] code;
        if (mods[MOD_FN]) begin
            code = LAYER_FN[idx];
        end else if (mods[MOD_SHIFT]) begin
            code = LAYER_SHIFT[idx];
        end else begin
            code = LAYER_NORMAL[idx];
        end
        return code;
    endfunction

endpackage

@@ design/lket_store.sv @@
// pressed-code store: one code per key, with per-entry valid bits cleared at reset
// read at item accept, written when the item leaves the input stage; uses lket_pkg
module lket_store #(
    parameter int NUM_KEYS = 53
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [lket_pkg::IDX_W-1:0]     i_rd_idx,
    input  logic [lket_pkg::IDX_W-1:0]     i_s1_idx,
    input  lket_pkg::t_store_wr            i_wr,
    output logic [lket_pkg::CODE_W-1:0]    o_rec_code
);

    localparam int AW = $clog2(NUM_KEYS);

    logic [lket_pkg::CODE_W-1:0] r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]         r_valid;
    logic [lket_pkg::CODE_W-1:0] r_rd_data;
    logic [lket_pkg::CODE_W-1:0] r_fwd_data;
    logic                        r_fwd;

    logic rd_in_range;
    logic s1_in_range;
    logic s1_valid;
    logic wr_hit;

    assign rd_in_range = {1'b0, i_rd_idx} < (lket_pkg::IDX_W + 1)'(NUM_KEYS);
    assign s1_in_range = {1'b0, i_s1_idx} < (lket_pkg::IDX_W + 1)'(NUM_KEYS);
    // a write landing on the same edge as the read would be missed by the memory
    assign wr_hit = i_wr.set && (i_wr.idx == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr.set) begin
            r_mem[i_wr.idx[AW-1:0]] <= i_wr.code;
        end
        if (i_rd_en && rd_in_range) begin
            r_rd_data <= r_mem[i_rd_idx[AW-1:0]];
        end
        if (i_rd_en && wr_hit) begin
            r_fwd_data <= i_wr.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr.set) begin
                r_valid[i_wr.idx[AW-1:0]] <= 1'b1;
            end else if (i_wr.clr) begin
                r_valid[i_wr.idx[AW-1:0]] <= 1'b0;
            end
            if (i_rd_en) begin
                r_fwd <= wr_hit;
            end
        end
    end

    assign s1_valid   = s1_in_range ? r_valid[i_s1_idx[AW-1:0]] : 1'b0;
    assign o_rec_code = !s1_valid ? '0 : (r_fwd ? r_fwd_data : r_rd_data);

endmodule

@@ design/lket_decode.sv @@
// event decode and layer translation for one registered fifo item
// produces the result item and the store update; uses lket_pkg
module lket_decode #(
    parameter int NUM_KEYS = 53
) (
    input  lket_pkg::t_in_item             i_item,
    input  logic [lket_pkg::CODE_W-1:0]    i_rec_code,
    output lket_pkg::t_out_item            o_res,
    output lket_pkg::t_store_wr            o_wr
);

    logic [1:0]                  ev_type;
    logic [lket_pkg::IDX_W-1:0]  idx;
    logic                        in_range;
    logic                        is_mod;
    logic [lket_pkg::CODE_W-1:0] lay_code;

    assign ev_type  = i_item.fifo_byte[1:0];
    assign idx      = i_item.fifo_byte[7:2];
    assign in_range = {1'b0, idx} < (lket_pkg::IDX_W + 1)'(NUM_KEYS);
    assign is_mod   = (idx == lket_pkg::KEY_SHIFT_L) || (idx == lket_pkg::KEY_SHIFT_R)
                   || (idx == lket_pkg::KEY_ALT) || (idx == lket_pkg::KEY_FN);
    assign lay_code = lket_pkg::layer_code(idx, i_item.modifier_status);

    always_comb begin
        o_res.event_kind  = lket_pkg::KIND_EMPTY;
        o_res.key_code    = '0;
        o_res.key_pressed = 1'b0;
        o_res.scan_index  = idx;
        o_wr.set  = 1'b0;
        o_wr.clr  = 1'b0;
        o_wr.idx  = idx;
        o_wr.code = lay_code;
        case (ev_type)
            lket_pkg::EV_NONE: begin
                o_res.scan_index = '0;
            end
            lket_pkg::EV_HOLD: begin
                o_res.event_kind = lket_pkg::KIND_HOLD;
            end
            default: begin
                o_res.key_pressed = (ev_type == lket_pkg::EV_PRESS);
                if (!in_range) begin
                    o_res.event_kind = lket_pkg::KIND_INVALID;
                end else if (is_mod) begin
                    o_res.event_kind = lket_pkg::KIND_MOD;
                end else if (idx == lket_pkg::KEY_CTRL) begin
                    o_res.event_kind = lket_pkg::KIND_CTRL;
                    o_res.key_code   = lket_pkg::CODE_LEFTCTRL;
                end else begin
                    o_res.event_kind = lket_pkg::KIND_KEY;
                    if (ev_type == lket_pkg::EV_PRESS) begin
                        o_res.key_code = lay_code;
                        o_wr.set       = 1'b1;
                    end else begin
                        // release under the code it was pressed with, if recorded
                        o_res.key_code = (i_rec_code != '0) ? i_rec_code : lay_code;
                        o_wr.clr       = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

@@ design/layered_keymap_event_translator.sv @@
// an accepted item is held in the input register; its result is registered in the
// output register when the item advances and is shown on the output from then on
// throughput: one item per cycle; the input stalls only when the result register
// is full and not taken. the store read is registered at accept and forwarded
// from a same-key write on that edge. reset clears the key records at once
// (valid flops, no clearing pass) and empties both stages
module layered_keymap_event_translator #(
    parameter int NUM_KEYS = 53
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lket_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lket_pkg::t_out_item o_out_data
);

    logic                        r_s1_vld;
    lket_pkg::t_in_item          r_s1;
    logic                        r_out_vld;
    lket_pkg::t_out_item         r_out;

    logic                        adv;
    logic                        accept;
    logic [lket_pkg::CODE_W-1:0] rec_code;
    lket_pkg::t_out_item         res;
    lket_pkg::t_store_wr         wr_raw;
    lket_pkg::t_store_wr         wr;

    assign adv        = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        wr     = wr_raw;
        wr.set = wr_raw.set && adv;
        wr.clr = wr_raw.clr && adv;
    end

    lket_store #(
        .NUM_KEYS (NUM_KEYS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_idx   (i_in_data.fifo_byte[7:2]),
        .i_s1_idx   (r_s1.fifo_byte[7:2]),
        .i_wr       (wr),
        .o_rec_code (rec_code)
    );

    lket_decode #(
        .NUM_KEYS (NUM_KEYS)
    ) u_decode (
        .i_item     (r_s1),
        .i_rec_code (rec_code),
        .o_res      (res),
        .o_wr       (wr_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a held input stage keeps its item
    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !adv |=> r_s1_vld)
        else $error("input stage item lost while stalled");

    // the store is only touched by an item that moves on
    a_wr_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.set || wr.clr) |-> adv && !(wr.set && wr.clr))
        else $error("store update without advancing item");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == lket_pkg::KIND_EMPTY) |->
        (o_out_data.key_code == '0) && !o_out_data.key_pressed
        && (o_out_data.scan_index == '0))
        else $error("empty fifo result carries data");

    a_ctrl_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == lket_pkg::KIND_CTRL) |->
        (o_out_data.key_code == lket_pkg::CODE_LEFTCTRL))
        else $error("ctrl result with wrong code");

    a_hold_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == lket_pkg::KIND_HOLD) |->
        (o_out_data.key_code == '0) && !o_out_data.key_pressed)
        else $error("hold result carries a key code");

endmodule
